FILE: design/imh_pkg.sv
// Shared types and constants of the indexed min-heap timer queue.
`timescale 1ns / 1ps
package imh_pkg;

  localparam int HEAP_DEPTH = 32;
  localparam int ID_COUNT   = 1024;

  localparam int FN_W   = 3;
  localparam int ID_W   = 10;
  localparam int TO_W   = 31;
  localparam int TM_W   = 48;
  localparam int ST_W   = 2;
  localparam int HA_W   = $clog2(HEAP_DEPTH);
  localparam int CNT_W  = $clog2(HEAP_DEPTH + 1);
  localparam int XW     = HA_W + 1;
  localparam int SID_AW = $clog2(ID_COUNT);

  localparam logic [TM_W-1:0] TIME_MAX = {TM_W{1'b1}};
  localparam logic [TO_W-1:0] WAIT_MAX = {TO_W{1'b1}};

  typedef enum logic [FN_W-1:0] {
    FN_ADD   = 3'd0,
    FN_ADJ   = 3'd1,
    FN_FIRE  = 3'd2,
    FN_TICK  = 3'd3,
    FN_POP   = 3'd4,
    FN_CLEAR = 3'd5
  } func_t;

  typedef enum logic [ST_W-1:0] {
    STS_OK      = 2'd0,
    STS_UNKNOWN = 2'd1,
    STS_FULL    = 2'd2,
    STS_EMPTY   = 2'd3
  } status_t;

  typedef enum logic [4:0] {
    ST_CLR, ST_IDLE, ST_DISP, ST_ID_HEAP, ST_ID_CHK, ST_DEL, ST_DEL_LAST,
    ST_DN_RD, ST_DN_L, ST_DN_R, ST_DN_DEC, ST_DN_END,
    ST_UP_RD, ST_UP_CMP, ST_FIN, ST_FIRE, ST_TICK_RD, ST_TICK_CHK, ST_STATUS
  } state_t;

  typedef struct packed {
    logic [TM_W-1:0] expiry;
    logic [ID_W-1:0] owner;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

FILE: design/imh_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module imh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

FILE: design/imh_cmp.sv
// Shared expiry comparator and wait subtractor.
`timescale 1ns / 1ps
module imh_cmp (
  input  logic [imh_pkg::TM_W-1:0] a,
  input  logic [imh_pkg::TM_W-1:0] b,
  output logic                     lt,
  output logic [imh_pkg::TO_W-1:0] wait_sat
);
  import imh_pkg::*;
  logic [TM_W-1:0] diff;

  assign lt   = a < b;
  assign diff = b - a;
  assign wait_sat = (diff[TM_W-1:TO_W] != '0) ? WAIT_MAX : diff[TO_W-1:0];
endmodule

FILE: design/indexed_min_heap_timer_queue.sv
// Top level of the indexed min-heap timer queue: sequencer and datapath.
//
//  channel | ports                                   | handshake
//  input   | in_func in_timer_id in_timeout_ms in_now_ms | start, busy
//  result  | out_event_kind .. out_last              | out_valid, one cycle
//
// Busy for fixed steps plus each heap level sifted down or up; a tick also adds
// fixed steps and the sift for each fired timer.
// The single read port of the heap RAM, with registered reads, sets the pace.
// After reset, busy stays high while the id table is swept.
// Results cannot be stalled; the block drives one word per cycle at most.
`timescale 1ns / 1ps
module indexed_min_heap_timer_queue (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [imh_pkg::FN_W-1:0]   in_func,
  input  logic [imh_pkg::ID_W-1:0]   in_timer_id,
  input  logic [imh_pkg::TO_W-1:0]   in_timeout_ms,
  input  logic [imh_pkg::TM_W-1:0]   in_now_ms,
  output logic                       out_valid,
  output logic                       out_event_kind,
  output logic [imh_pkg::ID_W-1:0]   out_event_id,
  output logic [imh_pkg::ST_W-1:0]   out_status,
  output logic [imh_pkg::TO_W-1:0]   out_next_wait_ms,
  output logic                       out_queue_empty,
  output logic                       out_last
);
  import imh_pkg::*;

  state_t            state_r, state_nxt;
  func_t             func_r, func_nxt;
  logic [ID_W-1:0]   id_r, id_nxt;
  logic [TM_W-1:0]   now_r, now_nxt;
  logic [TM_W-1:0]   exp_r, exp_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [SID_AW-1:0] clr_r, clr_nxt;
  logic [HA_W-1:0]   i_r, i_nxt;
  logic [HA_W-1:0]   s_r, s_nxt;
  entry_t            cur_r, cur_nxt;
  entry_t            ch_r, ch_nxt;
  logic [HA_W-1:0]   ch_idx_r, ch_idx_nxt;
  logic              moved_r, moved_nxt;
  logic              up_after_r, up_after_nxt;
  logic [ID_W-1:0]   who_r, who_nxt;
  status_t           status_r, status_nxt;
  logic [TO_W-1:0]   wait_r, wait_nxt;

  logic              ov_r, ov_nxt;
  logic              okind_r, okind_nxt;
  logic [ID_W-1:0]   oid_r, oid_nxt;
  logic [ST_W-1:0]   osts_r, osts_nxt;
  logic [TO_W-1:0]   owait_r, owait_nxt;
  logic              oqe_r, oqe_nxt;
  logic              olast_r, olast_nxt;

  logic              h_we;
  logic [HA_W-1:0]   h_waddr, h_raddr;
  entry_t            h_wdata, h_rdata;
  logic              s_we;
  logic [SID_AW-1:0] s_waddr, s_raddr;
  logic [HA_W-1:0]   s_wdata, s_rdata;

  logic [TM_W-1:0]   cmp_a, cmp_b;
  logic              cmp_lt;
  logic [TO_W-1:0]   cmp_wait;

  logic [TM_W:0]     sum;
  logic [XW-1:0]     c_left, c_right;
  logic [CNT_W-1:0]  n_last;
  logic              known;
  state_t            post_st;

  imh_ram #(.WIDTH(ENTRY_W), .DEPTH(HEAP_DEPTH)) u_heap (
    .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
    .raddr(h_raddr), .rdata(h_rdata)
  );

  imh_ram #(.WIDTH(HA_W), .DEPTH(ID_COUNT)) u_slot (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(s_raddr), .rdata(s_rdata)
  );

  imh_cmp u_cmp (.a(cmp_a), .b(cmp_b), .lt(cmp_lt), .wait_sat(cmp_wait));

  assign sum     = {1'b0, in_now_ms} + (TM_W + 1)'(in_timeout_ms);
  assign c_left  = {i_r, 1'b1};
  assign c_right = c_left + XW'(1);
  assign n_last  = count_r - CNT_W'(1);
  assign known   = (32'(id_r) < ID_COUNT) && (CNT_W'(s_r) < count_r)
                   && (h_rdata.owner == id_r);
  assign post_st = (func_r == FN_FIRE || func_r == FN_TICK) ? ST_FIRE : ST_STATUS;

  assign busy             = state_r != ST_IDLE;
  assign out_valid        = ov_r;
  assign out_event_kind   = okind_r;
  assign out_event_id     = oid_r;
  assign out_status       = osts_r;
  assign out_next_wait_ms = owait_r;
  assign out_queue_empty  = oqe_r;
  assign out_last         = olast_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLR;
      count_r <= '0;
      clr_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      clr_r   <= clr_nxt;
      ov_r    <= ov_nxt;
    end
    func_r     <= func_nxt;
    id_r       <= id_nxt;
    now_r      <= now_nxt;
    exp_r      <= exp_nxt;
    i_r        <= i_nxt;
    s_r        <= s_nxt;
    cur_r      <= cur_nxt;
    ch_r       <= ch_nxt;
    ch_idx_r   <= ch_idx_nxt;
    moved_r    <= moved_nxt;
    up_after_r <= up_after_nxt;
    who_r      <= who_nxt;
    status_r   <= status_nxt;
    wait_r     <= wait_nxt;
    okind_r    <= okind_nxt;
    oid_r      <= oid_nxt;
    osts_r     <= osts_nxt;
    owait_r    <= owait_nxt;
    oqe_r      <= oqe_nxt;
    olast_r    <= olast_nxt;
  end

  always_comb begin
    state_nxt    = state_r;
    func_nxt     = func_r;
    id_nxt       = id_r;
    now_nxt      = now_r;
    exp_nxt      = exp_r;
    count_nxt    = count_r;
    clr_nxt      = clr_r;
    i_nxt        = i_r;
    s_nxt        = s_r;
    cur_nxt      = cur_r;
    ch_nxt       = ch_r;
    ch_idx_nxt   = ch_idx_r;
    moved_nxt    = moved_r;
    up_after_nxt = up_after_r;
    who_nxt      = who_r;
    status_nxt   = status_r;
    wait_nxt     = wait_r;
    ov_nxt       = 1'b0;
    okind_nxt    = okind_r;
    oid_nxt      = oid_r;
    osts_nxt     = osts_r;
    owait_nxt    = owait_r;
    oqe_nxt      = oqe_r;
    olast_nxt    = olast_r;
    h_we         = 1'b0;
    h_waddr      = i_r;
    h_wdata      = cur_r;
    h_raddr      = '0;
    s_we         = 1'b0;
    s_waddr      = SID_AW'(cur_r.owner);
    s_wdata      = i_r;
    s_raddr      = SID_AW'(id_r);
    cmp_a        = h_rdata.expiry;
    cmp_b        = ch_r.expiry;

    unique case (state_r)
      ST_CLR: begin
        s_we    = 1'b1;
        s_waddr = clr_r;
        s_wdata = '0;
        clr_nxt = clr_r + SID_AW'(1);
        if (32'(clr_r) == ID_COUNT - 1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (start) begin
          func_nxt   = func_t'(in_func);
          id_nxt     = in_timer_id;
          now_nxt    = in_now_ms;
          exp_nxt    = sum[TM_W] ? TIME_MAX : sum[TM_W-1:0];
          status_nxt = STS_OK;
          wait_nxt   = '0;
          state_nxt  = ST_DISP;
        end
      end
      ST_DISP: begin
        case (func_r) inside
          FN_ADD, FN_ADJ, FN_FIRE: state_nxt = ST_ID_HEAP;
          FN_TICK: state_nxt = ST_TICK_RD;
          FN_POP: begin
            if (count_r == '0) begin
              status_nxt = STS_EMPTY;
              state_nxt  = ST_STATUS;
            end else begin
              i_nxt     = '0;
              state_nxt = ST_DEL;
            end
          end
          FN_CLEAR: begin
            count_nxt = '0;
            state_nxt = ST_STATUS;
          end
          default: state_nxt = ST_STATUS;
        endcase
      end
      ST_ID_HEAP: begin
        s_nxt     = s_rdata;
        h_raddr   = s_rdata;
        state_nxt = ST_ID_CHK;
      end
      ST_ID_CHK: begin
        cur_nxt.expiry = exp_r;
        cur_nxt.owner  = id_r;
        moved_nxt      = 1'b0;
        who_nxt        = id_r;
        i_nxt          = s_r;
        if (func_r == FN_ADD && !known && (32'(id_r) < ID_COUNT)) begin
          if (32'(count_r) >= HEAP_DEPTH) begin
            status_nxt = STS_FULL;
            state_nxt  = ST_STATUS;
          end else begin
            i_nxt     = HA_W'(count_r);
            count_nxt = count_r + CNT_W'(1);
            state_nxt = ST_UP_RD;
          end
        end else if (!known) begin
          status_nxt = STS_UNKNOWN;
          state_nxt  = ST_STATUS;
        end else if (func_r == FN_FIRE) begin
          state_nxt = ST_DEL;
        end else begin
          up_after_nxt = func_r == FN_ADD;
          state_nxt    = ST_DN_RD;
        end
      end
      ST_DEL: begin
        count_nxt = n_last;
        if (CNT_W'(i_r) < n_last) begin
          h_raddr   = HA_W'(n_last);
          state_nxt = ST_DEL_LAST;
        end else begin
          state_nxt = post_st;
        end
      end
      ST_DEL_LAST: begin
        cur_nxt      = h_rdata;
        moved_nxt    = 1'b0;
        up_after_nxt = 1'b1;
        state_nxt    = ST_DN_RD;
      end
      ST_DN_RD: begin
        h_raddr = HA_W'(c_left);
        if (c_left >= XW'(count_r)) begin
          state_nxt = ST_DN_END;
        end else begin
          state_nxt = ST_DN_L;
        end
      end
      ST_DN_L: begin
        ch_nxt     = h_rdata;
        ch_idx_nxt = HA_W'(c_left);
        h_raddr    = HA_W'(c_right);
        if (c_right < XW'(count_r)) begin
          state_nxt = ST_DN_R;
        end else begin
          state_nxt = ST_DN_DEC;
        end
      end
      ST_DN_R: begin
        cmp_a = h_rdata.expiry;
        cmp_b = ch_r.expiry;
        if (cmp_lt) begin
          ch_nxt     = h_rdata;
          ch_idx_nxt = HA_W'(c_right);
        end
        state_nxt = ST_DN_DEC;
      end
      ST_DN_DEC: begin
        cmp_a = cur_r.expiry;
        cmp_b = ch_r.expiry;
        if (cmp_lt) begin
          state_nxt = ST_DN_END;
        end else begin
          h_we      = 1'b1;
          h_wdata   = ch_r;
          s_we      = 1'b1;
          s_waddr   = SID_AW'(ch_r.owner);
          i_nxt     = ch_idx_r;
          moved_nxt = 1'b1;
          state_nxt = ST_DN_RD;
        end
      end
      ST_DN_END: begin
        state_nxt = (!moved_r && up_after_r) ? ST_UP_RD : ST_FIN;
      end
      ST_UP_RD: begin
        h_raddr = (i_r - HA_W'(1)) >> 1;
        state_nxt = (i_r == '0) ? ST_FIN : ST_UP_CMP;
      end
      ST_UP_CMP: begin
        cmp_a = h_rdata.expiry;
        cmp_b = cur_r.expiry;
        if (cmp_lt) begin
          state_nxt = ST_FIN;
        end else begin
          h_we      = 1'b1;
          h_wdata   = h_rdata;
          s_we      = 1'b1;
          s_waddr   = SID_AW'(h_rdata.owner);
          i_nxt     = (i_r - HA_W'(1)) >> 1;
          state_nxt = ST_UP_RD;
        end
      end
      ST_FIN: begin
        h_we      = 1'b1;
        s_we      = 1'b1;
        state_nxt = (func_r == FN_ADD || func_r == FN_ADJ) ? ST_STATUS : post_st;
      end
      ST_FIRE: begin
        ov_nxt    = 1'b1;
        okind_nxt = 1'b0;
        oid_nxt   = who_r;
        osts_nxt  = STS_OK;
        owait_nxt = '0;
        oqe_nxt   = count_r == '0;
        olast_nxt = 1'b0;
        state_nxt = (func_r == FN_TICK) ? ST_TICK_RD : ST_STATUS;
      end
      ST_TICK_RD: begin
        h_raddr   = '0;
        state_nxt = (count_r == '0) ? ST_STATUS : ST_TICK_CHK;
      end
      ST_TICK_CHK: begin
        cmp_a = now_r;
        cmp_b = h_rdata.expiry;
        if (cmp_lt) begin
          wait_nxt  = cmp_wait;
          state_nxt = ST_STATUS;
        end else begin
          who_nxt   = h_rdata.owner;
          i_nxt     = '0;
          state_nxt = ST_DEL;
        end
      end
      ST_STATUS: begin
        ov_nxt    = 1'b1;
        okind_nxt = 1'b1;
        oid_nxt   = '0;
        osts_nxt  = status_r;
        owait_nxt = wait_r;
        oqe_nxt   = count_r == '0;
        olast_nxt = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule

FILE: design/imh_chk.sv
// Port-level checker for the timer queue, bound to the top level.
`timescale 1ns / 1ps
module imh_chk (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     start,
  input logic                     busy,
  input logic                     out_valid,
  input logic                     out_event_kind,
  input logic [imh_pkg::ST_W-1:0] out_status,
  input logic [imh_pkg::TO_W-1:0] out_next_wait_ms,
  input logic                     out_last
);
  import imh_pkg::*;

  a_last_is_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_event_kind)
    else $error("final word is not a status");

  a_fire_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_event_kind |-> out_status == '0 && out_next_wait_ms == '0
    && !out_last)
    else $error("fired word carries status fields");

  a_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  a_more_follow: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |-> busy)
    else $error("idle before final word");
endmodule

bind indexed_min_heap_timer_queue imh_chk u_imh_chk (.*);

FILE: tb/sv/testbench.sv
// Self-checking testbench for the indexed min-heap timer queue.
`timescale 1ns / 1ps
module testbench;
  import imh_pkg::*;

  localparam logic [FN_W-1:0] FN_SPARE_A = 3'd6;
  localparam logic [FN_W-1:0] FN_SPARE_B = 3'd7;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  logic [FN_W-1:0]   in_func = '0;
  logic [ID_W-1:0]   in_timer_id = '0;
  logic [TO_W-1:0]   in_timeout_ms = '0;
  logic [TM_W-1:0]   in_now_ms = '0;
  logic              out_valid;
  logic              out_event_kind;
  logic [ID_W-1:0]   out_event_id;
  logic [ST_W-1:0]   out_status;
  logic [TO_W-1:0]   out_next_wait_ms;
  logic              out_queue_empty;
  logic              out_last;

  typedef struct packed {
    logic            kind;
    logic [ID_W-1:0] id;
    logic [ST_W-1:0] status;
    logic [TO_W-1:0] wait_ms;
    logic            empty;
    logic            last;
  } event_word_t;

  event_word_t pending_words[$];
  int          error_count = 0;
  bit          idle_enable = 1'b1;
  logic [TM_W-1:0] clock_ms = '0;

  logic [TM_W-1:0] mdl_expiry[HEAP_DEPTH];
  logic [ID_W-1:0] mdl_owner[HEAP_DEPTH];
  int              mdl_slot[ID_COUNT];
  bit              mdl_live[ID_COUNT];
  int              mdl_count = 0;

  indexed_min_heap_timer_queue i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_func(in_func), .in_timer_id(in_timer_id),
    .in_timeout_ms(in_timeout_ms), .in_now_ms(in_now_ms),
    .out_valid(out_valid), .out_event_kind(out_event_kind),
    .out_event_id(out_event_id), .out_status(out_status),
    .out_next_wait_ms(out_next_wait_ms), .out_queue_empty(out_queue_empty),
    .out_last(out_last)
  );

  always #2 clk = ~clk;

  initial begin
    #20000000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic void swap_slots(int a, int b);
    logic [TM_W-1:0] te;
    logic [ID_W-1:0] to;
    te = mdl_expiry[a];
    to = mdl_owner[a];
    mdl_expiry[a] = mdl_expiry[b];
    mdl_owner[a] = mdl_owner[b];
    mdl_expiry[b] = te;
    mdl_owner[b] = to;
    mdl_slot[mdl_owner[a]] = a;
    mdl_slot[mdl_owner[b]] = b;
  endfunction

  function automatic void sift_up(int i);
    int p;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (mdl_expiry[p] < mdl_expiry[i]) break;
      swap_slots(i, p);
      i = p;
    end
  endfunction

  function automatic bit sift_down(int first, int n);
    int i;
    int c;
    i = first;
    c = 2 * i + 1;
    while (c < n) begin
      if (c + 1 < n && mdl_expiry[c+1] < mdl_expiry[c]) c++;
      if (mdl_expiry[i] < mdl_expiry[c]) break;
      swap_slots(i, c);
      i = c;
      c = 2 * i + 1;
    end
    return i > first;
  endfunction

  function automatic void delete_slot(int i);
    int n;
    n = mdl_count - 1;
    if (i < n) begin
      swap_slots(i, n);
      if (!sift_down(i, n)) sift_up(i);
    end
    mdl_live[mdl_owner[n]] = 1'b0;
    mdl_count = n;
  endfunction

  function automatic logic [TM_W-1:0] expiry_at(logic [TM_W-1:0] now, logic [TO_W-1:0] dly);
    logic [TM_W:0] sum;
    sum = {1'b0, now} + (TM_W + 1)'(dly);
    return sum[TM_W] ? TIME_MAX : sum[TM_W-1:0];
  endfunction

  function automatic void push_word(logic kind, logic [ID_W-1:0] id, logic [ST_W-1:0] sts,
                                    logic [TO_W-1:0] w, logic last);
    event_word_t ew;
    ew.kind = kind;
    ew.id = id;
    ew.status = sts;
    ew.wait_ms = w;
    ew.empty = (mdl_count == 0);
    ew.last = last;
    pending_words = {pending_words, ew};
  endfunction

  function automatic void predict_timer_op(logic [FN_W-1:0] fn, logic [ID_W-1:0] id,
                                           logic [TO_W-1:0] dly, logic [TM_W-1:0] now);
    status_t sts;
    logic [TO_W-1:0] w;
    logic [TM_W-1:0] d;
    logic [ID_W-1:0] who;
    int i;
    sts = STS_OK;
    w = '0;
    case (fn)
      FN_ADD: begin
        if (!mdl_live[id]) begin
          if (mdl_count >= HEAP_DEPTH) sts = STS_FULL;
          else begin
            i = mdl_count;
            mdl_expiry[i] = expiry_at(now, dly);
            mdl_owner[i] = id;
            mdl_slot[id] = i;
            mdl_live[id] = 1'b1;
            mdl_count = i + 1;
            sift_up(i);
          end
        end else begin
          i = mdl_slot[id];
          mdl_expiry[i] = expiry_at(now, dly);
          if (!sift_down(i, mdl_count)) sift_up(i);
        end
      end
      FN_ADJ: begin
        if (!mdl_live[id]) sts = STS_UNKNOWN;
        else begin
          i = mdl_slot[id];
          mdl_expiry[i] = expiry_at(now, dly);
          void'(sift_down(i, mdl_count));
        end
      end
      FN_FIRE: begin
        if (!mdl_live[id]) sts = STS_UNKNOWN;
        else begin
          delete_slot(mdl_slot[id]);
          push_word(1'b0, id, STS_OK, '0, 1'b0);
        end
      end
      FN_TICK: begin
        while (mdl_count > 0 && mdl_expiry[0] <= now) begin
          who = mdl_owner[0];
          delete_slot(0);
          push_word(1'b0, who, STS_OK, '0, 1'b0);
        end
        if (mdl_count > 0) begin
          d = (mdl_expiry[0] > now) ? mdl_expiry[0] - now : '0;
          w = (d > WAIT_MAX) ? WAIT_MAX : d[TO_W-1:0];
        end
      end
      FN_POP: begin
        if (mdl_count == 0) sts = STS_EMPTY;
        else delete_slot(0);
      end
      FN_CLEAR: begin
        foreach (mdl_live[k]) mdl_live[k] = 1'b0;
        mdl_count = 0;
      end
      default: ;
    endcase
    push_word(1'b1, '0, sts, w, 1'b1);
  endfunction

  always @(posedge clk) begin
    event_word_t want;
    if (rst_n && out_valid) begin
      if (pending_words.size() == 0) begin
        $display("%0t: unexpected word kind=%0d id=%0d status=%0d", $time,
                 out_event_kind, out_event_id, out_status);
        error_count++;
      end else begin
        want = pending_words.pop_front();
        if (out_event_kind !== want.kind || out_event_id !== want.id ||
            out_status !== want.status || out_next_wait_ms !== want.wait_ms ||
            out_queue_empty !== want.empty || out_last !== want.last) begin
          $display("%0t: mismatch expected k=%0d id=%0d st=%0d w=%0d e=%0d l=%0d",
                   $time, want.kind, want.id, want.status, want.wait_ms, want.empty,
                   want.last);
          $display("%0t:          actual   k=%0d id=%0d st=%0d w=%0d e=%0d l=%0d",
                   $time, out_event_kind, out_event_id, out_status, out_next_wait_ms,
                   out_queue_empty, out_last);
          error_count++;
        end
      end
    end
  end

  task automatic send_op(logic [FN_W-1:0] fn, logic [ID_W-1:0] id,
                         logic [TO_W-1:0] dly, logic [TM_W-1:0] now);
    int gap;
    if (idle_enable && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 6);
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_func <= fn;
    in_timer_id <= id;
    in_timeout_ms <= dly;
    in_now_ms <= now;
    @(posedge clk);
    while (busy) @(posedge clk);
    predict_timer_op(fn, id, dly, now);
    start <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain_words();
    while (pending_words.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic test_directed_edges();
    send_op(FN_TICK, 10'd0, '0, '0);
    send_op(FN_POP, 10'd0, '0, '0);
    send_op(FN_ADJ, 10'd5, 31'd10, '0);
    send_op(FN_FIRE, 10'd1023, '0, '0);
    send_op(FN_ADD, 10'd1023, WAIT_MAX, TIME_MAX);
    send_op(FN_ADD, 10'd0, '0, TIME_MAX - 48'd5);
    send_op(FN_ADD, 10'd7, 31'd100, '0);
    send_op(FN_ADD, 10'd8, 31'd100, '0);
    send_op(FN_ADD, 10'd7, 31'd50, '0);
    send_op(FN_ADJ, 10'd8, 31'd20, '0);
    send_op(FN_TICK, 10'd0, '0, 48'd20);
    send_op(FN_FIRE, 10'd7, '0, '0);
    send_op(FN_TICK, 10'd0, '0, '0);
    send_op(FN_SPARE_A, 10'h2AA, 31'h2AAAAAAA, 48'hAAAA_AAAA_AAAA);
    send_op(FN_SPARE_B, 10'h155, 31'h55555555, 48'h5555_5555_5555);
    send_op(FN_POP, 10'd0, '0, '0);
    send_op(FN_TICK, 10'd0, '0, TIME_MAX);
    for (int k = 0; k < HEAP_DEPTH + 1; k++)
      send_op(FN_ADD, ID_W'(k * 3), 31'd1000 - 31'(k * 7), 48'd0);
    send_op(FN_CLEAR, 10'd0, '0, '0);
    drain_words();
  endtask

  function automatic logic [FN_W-1:0] FN_FIELD_NOISE(int r);
    return (r & 1) ? FN_SPARE_B : FN_SPARE_A;
  endfunction

  task automatic test_random_ops(int n_ops);
    logic [FN_W-1:0] fn;
    logic [ID_W-1:0] id;
    logic [TO_W-1:0] dly;
    logic [TM_W-1:0] now;
    int r;
    for (int n = 0; n < n_ops; n++) begin
      r = $urandom_range(0, 99);
      if (r < 40) fn = FN_ADD;
      else if (r < 52) fn = FN_ADJ;
      else if (r < 64) fn = FN_FIRE;
      else if (r < 82) fn = FN_TICK;
      else if (r < 92) fn = FN_POP;
      else if (r < 95) fn = FN_CLEAR;
      else fn = FN_FIELD_NOISE(r);
      id = ($urandom_range(0, 3) == 0) ? ID_W'($urandom) : ID_W'($urandom_range(0, 40));
      if ($urandom_range(0, 9) == 0) dly = TO_W'($urandom);
      else dly = TO_W'($urandom_range(0, 200));
      clock_ms = clock_ms + TM_W'($urandom_range(0, 60));
      now = clock_ms;
      if ($urandom_range(0, 19) == 0) now = TM_W'({$urandom, $urandom});
      send_op(fn, id, dly, now);
    end
  endtask

  task automatic test_fill_and_drain();
    for (int k = 0; k < HEAP_DEPTH; k++)
      send_op(FN_ADD, ID_W'($urandom_range(0, 1023)), TO_W'($urandom_range(0, 30)),
              clock_ms);
    send_op(FN_TICK, 10'd0, '0, clock_ms + 48'd15);
    send_op(FN_TICK, 10'd0, '0, clock_ms + 48'd40);
  endtask

  initial begin
    foreach (mdl_live[k]) mdl_live[k] = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_edges();
    test_random_ops(100);
    drain_words();
    test_fill_and_drain();
    idle_enable = 1'b0;
    test_random_ops(60);
    drain_words();
    repeat (200) @(posedge clk);
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
